FILE: rtl/atdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package atdd_pkg;
  localparam int MaxVertices = 32;
  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeRemove = 2'd1;
  localparam logic [1:0] ModeSearch = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StBadSrc = 3'd1;
  localparam logic [2:0] StBadDst = 3'd2;
  localparam logic [2:0] StMissing = 3'd3;
  localparam logic [2:0] StFull = 3'd4;
  localparam logic [1:0] RegVertexCount = 2'd0;
  localparam logic [1:0] RegMaxDegree = 2'd1;
  localparam logic [1:0] RegWeighted = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/atdd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module atdd_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic [5:0]       vertex_count,
  output logic [5:0]       max_degree,
  output logic             weighted
);
  import atdd_pkg::*;
  logic [1:0] idx;
  assign idx = paddr[3:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 6'd32;
      max_degree <= 6'd32;
      weighted <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (idx)
        RegVertexCount: vertex_count <= pwdata[5:0];
        RegMaxDegree: max_degree <= pwdata[5:0];
        RegWeighted: weighted <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      case (idx)
        RegVertexCount: prdata = {26'd0, vertex_count};
        RegMaxDegree: prdata = {26'd0, max_degree};
        RegWeighted: prdata = {31'd0, weighted};
        default: prdata = '0;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/adjacency_table_with_dfs_depth.sv
`timescale 1ns / 1ps
`default_nettype none
// Adjacency-list graph store. Insert writes the source's neighbour list, and
// also the target's when undirected; remove scans the neighbour list one
// entry a cycle (both lists when undirected); depth search clears labels,
// then walks every edge of reached vertices, each neighbour-memory read
// taking a walk state and a check state, then emits one item per vertex in
// use. All steps share one sequencer and the neighbour and weight memories,
// each with one write and one read port. Not ready while an item is in progress.
module adjacency_table_with_dfs_depth #(
  parameter int MAX_VERTICES = atdd_pkg::MaxVertices
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [5:0]  source_vertex,
  input  wire logic [5:0]  target_vertex,
  input  wire logic        directed,
  input  wire logic signed [15:0] edge_weight,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [4:0]       vertex_index,
  output logic [5:0]       depth_label,
  output logic             last
);
  import atdd_pkg::*;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = VW + 1;
  localparam int AW = 2 * VW;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_INS = 10'b0000000010, S_SCAN = 10'b0000000100,
    S_RDLAST = 10'b0000001000, S_MOVE = 10'b0000010000, S_CLR = 10'b0000100000,
    S_WALK = 10'b0001000000, S_WCHK = 10'b0010000000, S_EMIT = 10'b0100000000,
    S_OUT = 10'b1000000000
  } state_t;

  logic [5:0] vertex_count, max_degree;
  logic weighted;
  assign pready = 1'b1;
  atdd_cfg u_cfg (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .vertex_count, .max_degree, .weighted);

  logic [VW-1:0] nbr_mem [2**AW];
  logic [15:0]   wt_mem  [2**AW];
  logic [CW-1:0] deg [MAX_VERTICES];
  logic [5:0]    lbl [MAX_VERTICES];
  logic [VW-1:0] stk_v [MAX_VERTICES];
  logic [CW-1:0] stk_n [MAX_VERTICES];

  state_t state;
  logic [1:0] op;
  logic [VW-1:0] a, b, cur_v, found_i;
  logic dir, second, rev;
  logic [15:0] wt, wt_rd;
  logic [VW-1:0] nbr_rd;
  logic [CW-1:0] idx, nv, md;
  logic [CW:0] sp;
  logic [2:0] st_r;
  logic [VW-1:0] vi_r;
  logic [5:0] lbl_r;
  logic last_r;

  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [VW-1:0] mem_wd;
  logic [15:0] mem_wwd;

  always_comb begin
    nv = ({1'b0, vertex_count} > 7'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                  : CW'(vertex_count);
    md = ({1'b0, max_degree} > 7'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                : CW'(max_degree);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      nbr_mem[mem_wa] <= mem_wd;
      if (weighted) wt_mem[mem_wa] <= mem_wwd;
    end
    nbr_rd <= nbr_mem[mem_ra];
    wt_rd <= wt_mem[mem_ra];
  end

  logic [VW-1:0] top_v;
  logic [CW-1:0] top_n, top_d;
  assign top_v = stk_v[sp[VW-1:0] - VW'(1)];
  assign top_n = stk_n[sp[VW-1:0] - VW'(1)];
  assign top_d = deg[top_v];

  always_comb begin
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_wwd = wt; mem_ra = '0;
    case (state)
      S_INS: begin
        mem_we = 1'b1;
        mem_wa = second ? {b, deg[b][VW-1:0]} : {a, deg[a][VW-1:0]};
        mem_wd = second ? a : b;
      end
      S_SCAN: mem_ra = {a, idx[VW-1:0]};
      S_RDLAST: mem_ra = {a, VW'(deg[a] - CW'(1))};
      S_MOVE: begin
        mem_we = 1'b1; mem_wa = {a, found_i}; mem_wd = nbr_rd; mem_wwd = wt_rd;
      end
      S_WALK: mem_ra = {top_v, top_n[VW-1:0]};
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign status = st_r;
  assign vertex_index = 5'(vi_r);
  assign depth_label = lbl_r;
  assign last = last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        deg[i] <= '0; lbl[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          op <= mode; a <= VW'(source_vertex); b <= VW'(target_vertex);
          dir <= directed; wt <= edge_weight; second <= 1'b0; rev <= 1'b0;
          idx <= '0; sp <= '0;
          vi_r <= '0; lbl_r <= '0; last_r <= 1'b1;
          if (mode == ModeUnused) begin
            st_r <= StOk; state <= S_IDLE;
          end else if ({1'b0, source_vertex} >= 7'(nv)) begin
            st_r <= StBadSrc; state <= S_OUT;
          end else if (mode == ModeSearch) begin
            st_r <= StOk; state <= S_CLR;
          end else if ({1'b0, target_vertex} >= 7'(nv)) begin
            st_r <= StBadDst; state <= S_OUT;
          end else if (mode == ModeInsert) begin
            if (!directed && source_vertex == target_vertex) begin
              if ((CW+1)'(deg[VW'(source_vertex)]) + (CW+1)'(2) > (CW+1)'(md)) begin
                st_r <= StFull; state <= S_OUT;
              end else begin
                st_r <= StOk; state <= S_INS;
              end
            end else if ((CW+1)'(deg[VW'(source_vertex)]) + (CW+1)'(1) > (CW+1)'(md)
              || (!directed && (CW+1)'(deg[VW'(target_vertex)]) + (CW+1)'(1)
                  > (CW+1)'(md))) begin
              st_r <= StFull; state <= S_OUT;
            end else begin
              st_r <= StOk; state <= S_INS;
            end
          end else begin
            st_r <= StOk; state <= S_SCAN;
          end
        end
        S_INS: begin
          if (!second) begin
            deg[a] <= deg[a] + CW'(1);
            if (!dir) second <= 1'b1; else state <= S_OUT;
          end else begin
            deg[b] <= deg[b] + CW'(1); state <= S_OUT;
          end
        end
        S_SCAN: begin
          // idx issued this cycle; compare previous read
          if (idx != '0 && nbr_rd == b) begin
            found_i <= VW'(idx - CW'(1)); state <= S_RDLAST;
          end else if (idx == deg[a]) begin
            if (!rev) st_r <= StMissing;
            state <= S_OUT;
          end else idx <= idx + CW'(1);
        end
        S_RDLAST: state <= S_MOVE;
        S_MOVE: begin
          deg[a] <= deg[a] - CW'(1);
          if (!dir && !rev) begin
            rev <= 1'b1; a <= b; b <= a; idx <= '0; state <= S_SCAN;
          end else state <= S_OUT;
        end
        S_CLR: begin
          for (int i = 0; i < MAX_VERTICES; i++)
            lbl[i] <= (VW'(i) == a) ? 6'd1 : 6'd0;
          stk_v[0] <= a; stk_n[0] <= '0; sp <= (CW+1)'(1);
          state <= S_WALK;
        end
        S_WALK: begin
          if (sp == '0) begin
            idx <= '0; state <= S_EMIT;
          end else if (top_n < top_d) begin
            stk_n[sp[VW-1:0] - VW'(1)] <= top_n + CW'(1);
            state <= S_WCHK;
          end else sp <= sp - (CW+1)'(1);
        end
        S_WCHK: begin
          if ((CW)'(nbr_rd) < nv && lbl[nbr_rd] == '0
              && sp < (CW+1)'(MAX_VERTICES)) begin
            lbl[nbr_rd] <= 6'(sp + (CW+1)'(1));
            stk_v[sp[VW-1:0]] <= nbr_rd; stk_n[sp[VW-1:0]] <= '0;
            sp <= sp + (CW+1)'(1);
          end
          state <= S_WALK;
        end
        S_EMIT: begin
          vi_r <= idx[VW-1:0]; lbl_r <= lbl[idx[VW-1:0]];
          last_r <= (idx + CW'(1) == nv); st_r <= StOk;
          idx <= idx + CW'(1); state <= S_OUT; op <= ModeSearch;
        end
        S_OUT: if (out_ready) begin
          if (op == ModeSearch && !last_r && st_r == StOk) state <= S_EMIT;
          else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
